// ===== rtl/ilut_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_pkg
// Shared types and constants of the interpolating lookup table.
// ----------------------------------------------------------------------------
package ilut_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int INDEX_W     = 10;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN    = 2'd0,
    CFG_X_MAX    = 2'd1,
    CFG_INV_DX   = 2'd2,
    CFG_NUM_DIVS = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_min;
    logic signed [DATA_W-1:0] x_max;
    logic [DATA_W-1:0]        inv_dx;
    logic [INDEX_W-1:0]       num_divs;
    logic [TABLE_AW-1:0]      last;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
    logic [DATA_W-1:0]   data;
  } ram_wr_t;

  typedef struct packed {
    logic              valid;
    region_e           region;
    logic [FRAC_W-1:0] frac;
  } lookup_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] y;
    region_e           region;
  } result_t;

endpackage

// ===== rtl/ilut_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilut_ram #(
  parameter int DataWidth = 32,
  parameter int Depth     = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ilut_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_index
// Front stages: domain check, scaling multiply, entry address generation
// and table write.
// ----------------------------------------------------------------------------
module ilut_index import ilut_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic                     kind_i,
  input  logic [INDEX_W-1:0]       entry_index_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  cfg_t                     cfg_i,
  output ram_wr_t                  wr_o,
  output logic [TABLE_AW-1:0]      rd_addr_a_o,
  output logic [TABLE_AW-1:0]      rd_addr_b_o,
  output lookup_ctl_t              ctl_o
);

  // Stage 1
  logic               s1_valid_q;
  kind_e              s1_kind_q;
  logic [INDEX_W-1:0] s1_index_q;
  logic [DATA_W-1:0]  s1_value_q;
  region_e            s1_region_q;
  logic [DATA_W-1:0]  s1_diff_q;
  region_e            s1_region_d;
  logic [DATA_W-1:0]  s1_diff_d;

  // Stage 2
  logic               s2_valid_q;
  kind_e              s2_kind_q;
  logic [INDEX_W-1:0] s2_index_q;
  logic [DATA_W-1:0]  s2_value_q;
  region_e            s2_region_q;
  logic [DATA_W-1:0]  s2_idx_q;
  logic [FRAC_W-1:0]  s2_frac_q;
  logic [2*DATA_W-1:0] s2_prod_d;

  // Stage 3
  lookup_ctl_t         ctl_q;
  lookup_ctl_t         ctl_d;
  logic                flat;
  logic [TABLE_AW-1:0] addr_a;

  always_comb begin
    s1_diff_d = DATA_W'(x_i - cfg_i.x_min);
    if (x_i <= cfg_i.x_min) begin
      s1_region_d = REGION_BELOW;
    end else if (x_i >= cfg_i.x_max) begin
      s1_region_d = REGION_ABOVE;
    end else begin
      s1_region_d = REGION_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      ctl_q      <= '0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      ctl_q      <= ctl_d;
    end
  end

  assign s2_prod_d = (2*DATA_W)'(s1_diff_q) * (2*DATA_W)'(cfg_i.inv_dx);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_kind_q   <= kind_e'(kind_i);
      s1_index_q  <= entry_index_i;
      s1_value_q  <= entry_value_i;
      s1_region_q <= s1_region_d;
      s1_diff_q   <= s1_diff_d;

      s2_kind_q   <= s1_kind_q;
      s2_index_q  <= s1_index_q;
      s2_value_q  <= s1_value_q;
      s2_region_q <= s1_region_q;
      s2_idx_q    <= s2_prod_d[2*DATA_W-1:DATA_W];
      s2_frac_q   <= s2_prod_d[DATA_W-1:DATA_W-FRAC_W];
    end
  end

  always_comb begin
    flat = (s2_region_q != REGION_INSIDE)
        || (s2_idx_q >= DATA_W'(cfg_i.num_divs))
        || (s2_idx_q >= DATA_W'(cfg_i.last));
    if (s2_region_q == REGION_BELOW) begin
      addr_a = '0;
    end else if (flat) begin
      addr_a = cfg_i.last;
    end else begin
      addr_a = TABLE_AW'(s2_idx_q);
    end
    ctl_d.valid  = s2_valid_q && (s2_kind_q == KIND_LOOKUP);
    ctl_d.region = s2_region_q;
    ctl_d.frac   = flat ? '0 : s2_frac_q;
  end

  assign rd_addr_a_o = addr_a;
  assign rd_addr_b_o = flat ? addr_a : addr_a + TABLE_AW'(1);

  assign wr_o.en   = en_i && s2_valid_q && (s2_kind_q == KIND_WRITE)
                  && (32'(s2_index_q) < 32'(TABLE_DEPTH));
  assign wr_o.addr = TABLE_AW'(s2_index_q);
  assign wr_o.data = s2_value_q;

  assign ctl_o = ctl_q;

endmodule

// ===== rtl/ilut_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_blend
// Back stages: linear blend of two neighboring entries with
// round-half-up on the fraction.
// ----------------------------------------------------------------------------
module ilut_blend import ilut_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lookup_ctl_t       ctl_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  // Stage 4
  logic                     s4_valid_q;
  region_e                  s4_region_q;
  logic [FRAC_W-1:0]        s4_frac_q;
  logic [DATA_W-1:0]        s4_a_q;
  logic signed [DIFF_W-1:0] s4_diff_q;
  logic signed [DIFF_W-1:0] s4_diff_d;

  // Stage 5
  logic                     s5_valid_q;
  region_e                  s5_region_q;
  logic [DATA_W-1:0]        s5_a_q;
  logic signed [PROD_W-1:0] s5_prod_q;
  logic signed [PROD_W-1:0] s5_prod_d;

  // Stage 6
  logic                     s6_valid_q;
  result_t                  s6_res_q;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic [DATA_W-1:0]        y_d;

  assign s4_diff_d = $signed({b_i[DATA_W-1], b_i}) - $signed({a_i[DATA_W-1], a_i});
  assign s5_prod_d = s4_diff_q * $signed({1'b0, s4_frac_q});
  assign rounded   = s5_prod_q + (PROD_W'(1) <<< (FRAC_W - 1));
  assign shifted   = rounded >>> FRAC_W;
  assign y_d       = s5_a_q + shifted[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= ctl_i.valid;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_region_q <= ctl_i.region;
      s4_frac_q   <= ctl_i.frac;
      s4_a_q      <= a_i;
      s4_diff_q   <= s4_diff_d;

      s5_region_q <= s4_region_q;
      s5_a_q      <= s4_a_q;
      s5_prod_q   <= s5_prod_d;

      s6_res_q.region <= s5_region_q;
      s6_res_q.y      <= y_d;
    end
  end

  assign res_valid_o = s6_valid_q;
  assign res_o       = s6_res_q;

endmodule

// ===== rtl/ilut_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_skid
// Two-entry output buffer that decouples the pipeline from the consumer.
// ----------------------------------------------------------------------------
module ilut_skid import ilut_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  input  result_t push_data_i,
  output logic    room_o,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output result_t pop_data_o
);

  localparam logic [1:0] SkidDepth = 2'd2;

  logic [1:0] count_q;
  logic [1:0] count_d;
  result_t    head_q;
  result_t    tail_q;
  logic       push;
  logic       pop;

  assign room_o      = (count_q != SkidDepth);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_data_o  = head_q;
  assign push        = push_valid_i && room_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && (count_q == 2'd1)) begin
        head_q <= push_data_i;
      end else begin
        head_q <= tail_q;
      end
    end else if (push) begin
      if (count_q == 2'd0) begin
        head_q <= push_data_i;
      end else begin
        tail_q <= push_data_i;
      end
    end
  end

endmodule

// ===== rtl/interpolating_lookup_table.sv =====
`timescale 1ns / 1ps
// Linear-interpolation lookup table over a signed Q16.16 domain. Write
// transactions (kind 0) store a sample; lookup transactions (kind 1) return
// one result each, clamped below x_min or above x_max, otherwise blended
// between two neighboring samples. The block takes one transaction per clock
// and a lookup passes three front stages (domain check, 32x32 scaling
// multiply, address and RAM read), three blend stages, then a two-entry
// output buffer. The rate is set by that buffer: acceptance pauses only
// while both of its entries hold results the consumer has not taken. The
// table is kept in two RAM copies so both neighbors are read in the same
// cycle; writes retire in pipeline order, so a lookup always sees every
// write accepted before it.
// ----------------------------------------------------------------------------
// interpolating_lookup_table
// Top level: configuration registers, pipeline, table RAMs, output buffer.
// ----------------------------------------------------------------------------
module interpolating_lookup_table import ilut_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     kind_i,
  input  logic [INDEX_W-1:0]       entry_index_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] x_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] y_o,
  output logic [1:0]               region_o
);

  cfg_t                cfg_q;
  logic                en;
  ram_wr_t             wr;
  logic [TABLE_AW-1:0] rd_addr_a;
  logic [TABLE_AW-1:0] rd_addr_b;
  lookup_ctl_t         ctl;
  logic [DATA_W-1:0]   rd_a;
  logic [DATA_W-1:0]   rd_b;
  logic                res_valid;
  result_t             res;
  result_t             out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_X_MIN:    cfg_q.x_min  <= cfg_data_i;
        CFG_X_MAX:    cfg_q.x_max  <= cfg_data_i;
        CFG_INV_DX:   cfg_q.inv_dx <= cfg_data_i;
        CFG_NUM_DIVS: begin
          cfg_q.num_divs <= cfg_data_i[INDEX_W-1:0];
          cfg_q.last <= (32'(cfg_data_i[INDEX_W-1:0]) > 32'(TABLE_DEPTH - 1))
                      ? TABLE_AW'(TABLE_DEPTH - 1)
                      : TABLE_AW'(cfg_data_i[INDEX_W-1:0]);
        end
      endcase
    end
  end

  assign in_ready_o = en;

  ilut_index u_index (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (in_valid_i),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .x_i           (x_i),
    .cfg_i         (cfg_q),
    .wr_o          (wr),
    .rd_addr_a_o   (rd_addr_a),
    .rd_addr_b_o   (rd_addr_b),
    .ctl_o         (ctl)
  );

  ilut_ram #(
    .DataWidth (DATA_W),
    .Depth     (TABLE_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (en),
    .raddr_i (rd_addr_a),
    .rdata_o (rd_a)
  );

  ilut_ram #(
    .DataWidth (DATA_W),
    .Depth     (TABLE_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (en),
    .raddr_i (rd_addr_b),
    .rdata_o (rd_b)
  );

  ilut_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl),
    .a_i         (rd_a),
    .b_i         (rd_b),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ilut_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_data_i  (res),
    .room_o       (en),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (out_res)
  );

  assign y_o      = out_res.y;
  assign region_o = out_res.region;

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_stall_from_consumer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled while consumer was taking results");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interpolating lookup table. A generator fills
// a queue of write and lookup transactions per phase; a clocked driver offers
// them and predicts each lookup result on acceptance, and a clocked monitor
// compares every result with the oldest prediction. Phases cover directed
// corner cases, several domain settings with their extremes, random sender
// and receiver idling, and one long receiver hold-off that backs up the pipe.
// ----------------------------------------------------------------------------
module testbench;
  import ilut_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 64;
  localparam int PHASE_ITEMS   = 80;

  typedef struct {
    kind_e                    kind;
    logic [INDEX_W-1:0]       slot;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] x;
  } table_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] y;
    region_e                  region;
  } lookup_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  cfg_index_e               cfg_index_i = CFG_X_MIN;
  logic [DATA_W-1:0]        cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  kind_e                    kind_i = KIND_WRITE;
  logic [INDEX_W-1:0]       entry_index_i = '0;
  logic signed [DATA_W-1:0] entry_value_i = '0;
  logic signed [DATA_W-1:0] x_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] y_o;
  logic [1:0]               region_o;

  logic signed [DATA_W-1:0] lo_bound = '0;
  logic signed [DATA_W-1:0] hi_bound = '0;
  logic [DATA_W-1:0]        inv_step = '0;
  logic [INDEX_W-1:0]       div_count = '0;
  logic signed [DATA_W-1:0] sample_shadow [TABLE_DEPTH];
  bit                       slot_loaded [TABLE_DEPTH];

  table_op_t      table_ops_q[$];
  lookup_result_t expected_lookups[$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off_en = 1'b0;
  int hold_count = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  interpolating_lookup_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .x_i           (x_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .y_o           (y_o),
    .region_o      (region_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void locate(input logic signed [DATA_W-1:0] x,
                                 output int unsigned lo, output int unsigned hi,
                                 output logic [FRAC_W-1:0] frac,
                                 output region_e region);
    int unsigned last_slot;
    logic [63:0] offset;
    logic [63:0] scaled;
    last_slot = (div_count > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : div_count;
    lo = 0;
    hi = 0;
    frac = '0;
    if (x <= lo_bound) begin
      region = REGION_BELOW;
    end else if (x >= hi_bound) begin
      region = REGION_ABOVE;
      lo = last_slot;
      hi = last_slot;
    end else begin
      region = REGION_INSIDE;
      offset = 64'(longint'(x) - longint'(lo_bound));
      scaled = offset * {32'd0, inv_step};
      if (scaled[63:32] >= div_count) begin
        lo = last_slot;
        hi = last_slot;
      end else begin
        lo = (scaled[63:32] > last_slot) ? last_slot : scaled[63:32];
        hi = (lo + 1 > last_slot) ? last_slot : lo + 1;
        frac = scaled[31:16];
      end
    end
  endfunction

  // round half toward plus infinity
  function automatic logic signed [DATA_W-1:0] blend(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] b,
                                                     logic [FRAC_W-1:0] frac);
    longint weight;
    longint acc;
    weight = frac;
    acc = longint'(a) * (65536 - weight) + longint'(b) * weight + 32768;
    return 32'(acc >>> 16);
  endfunction

  function automatic void push_write(int unsigned slot, logic [DATA_W-1:0] value);
    table_op_t op;
    op.kind = KIND_WRITE;
    op.slot = slot[INDEX_W-1:0];
    op.value = value;
    op.x = $urandom;
    table_ops_q.insert(table_ops_q.size(), op);
    slot_loaded[slot] = 1'b1;
  endfunction

  // load any entry the lookup would read before offering it
  function automatic void push_lookup(logic signed [DATA_W-1:0] x);
    table_op_t op;
    int unsigned lo;
    int unsigned hi;
    logic [FRAC_W-1:0] frac;
    region_e region;
    locate(x, lo, hi, frac, region);
    if (!slot_loaded[lo]) push_write(lo, $urandom);
    if (!slot_loaded[hi]) push_write(hi, $urandom);
    op.kind = KIND_LOOKUP;
    op.slot = $urandom_range(TABLE_DEPTH - 1);
    op.value = $urandom;
    op.x = x;
    table_ops_q.insert(table_ops_q.size(), op);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_x();
    longint lo_b;
    longint hi_b;
    lo_b = lo_bound;
    hi_b = hi_bound;
    case ($urandom_range(9))
      0: return $urandom;
      1: return lo_bound;
      2: return hi_bound;
      3: return 32'(lo_b + 1);
      4: return 32'(hi_b - 1);
      5: return 32'(lo_b - $urandom_range(1 << 20));
      6: return 32'(hi_b + $urandom_range(1 << 20));
      default: begin
        if (hi_b > lo_b + 1)
          return 32'(lo_b + 1 + longint'({$urandom, $urandom} % 64'(hi_b - lo_b - 1)));
        return $urandom;
      end
    endcase
  endfunction

  task automatic write_reg(cfg_index_e idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_X_MIN:    lo_bound = value;
      CFG_X_MAX:    hi_bound = value;
      CFG_INV_DX:   inv_step = value;
      CFG_NUM_DIVS: div_count = value[INDEX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_domain(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                                logic [DATA_W-1:0] inv, logic [INDEX_W-1:0] divs);
    write_reg(CFG_X_MIN, lo);
    write_reg(CFG_X_MAX, hi);
    write_reg(CFG_INV_DX, inv);
    write_reg(CFG_NUM_DIVS, {22'd0, divs});
  endtask

  task automatic wait_idle();
    while (table_ops_q.size() != 0 || in_valid_i || expected_lookups.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : driver
    table_op_t op;
    int unsigned lo;
    int unsigned hi;
    logic [FRAC_W-1:0] frac;
    region_e region;
    lookup_result_t res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (kind_i == KIND_WRITE) begin
          if (int'(entry_index_i) < TABLE_DEPTH) sample_shadow[entry_index_i] = entry_value_i;
        end else begin
          locate(x_i, lo, hi, frac, region);
          res.y = blend(sample_shadow[lo], sample_shadow[hi], frac);
          res.region = region;
          expected_lookups.insert(expected_lookups.size(), res);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (table_ops_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          op = table_ops_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= op.kind;
          entry_index_i <= op.slot;
          entry_value_i <= op.value;
          x_i <= op.x;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    lookup_result_t res;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result, expected none, got y=%h region=%0d",
                   $time, y_o, region_o);
          mismatches++;
        end else begin
          res = expected_lookups.pop_front();
          if (y_o !== res.y) begin
            $display("%0t: y mismatch, expected %h, got %h", $time, res.y, y_o);
            mismatches++;
          end
          if (region_o !== res.region) begin
            $display("%0t: region mismatch, expected %0d, got %0d", $time, res.region,
                     region_o);
            mismatches++;
          end
        end
      end
      if (hold_off_en && hold_count < HOLD_CYCLES) begin
        out_ready_i <= 1'b0;
        hold_count <= hold_count + 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sender_plan [4];
    int stall_plan [4];
    int unsigned divs;
    longint lo_b;
    longint span;
    logic [63:0] inv;
    sender_plan = '{0, 64, 0, 21};
    stall_plan  = '{0, 0, 64, 21};
    for (int i = 0; i < TABLE_DEPTH; i++) sample_shadow[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // registers at reset: degenerate domain, single entry
    push_write(0, 32'h7fff_ffff);
    push_lookup(32'h0000_0000);
    push_lookup(32'h8000_0000);
    push_lookup(32'h7fff_ffff);
    wait_idle();

    program_domain(32'h0000_0000, 32'h0004_0000, 32'h0001_0000, 10'd4);
    push_write(0, 32'h8000_0000);
    push_write(1, 32'h7fff_ffff);
    push_write(2, 32'h0000_0000);
    push_write(3, 32'hffff_ffff);
    push_write(4, 32'h0001_0000);
    push_lookup(32'h0000_0000);
    push_lookup(32'h0004_0000);
    push_lookup(32'h0000_0001);
    push_lookup(32'h0001_8000);
    push_lookup(32'h0002_8000);
    push_lookup(32'h0003_ffff);
    push_lookup(32'h8000_0000);
    push_lookup(32'h7fff_ffff);
    wait_idle();

    // index past the last entry, then zero step
    program_domain(32'hfff8_0000, 32'h0008_0000, 32'h0001_0000, 10'd4);
    push_lookup(32'h0001_0000);
    push_lookup(32'hfff8_8000);
    wait_idle();
    write_reg(CFG_INV_DX, 32'h0000_0000);
    push_lookup(32'h0003_0000);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      sender_idle_pct = sender_plan[p / 2];
      stall_pct = stall_plan[p / 2];
      if (p == 0) begin
        program_domain(32'h8000_0000, 32'h7fff_ffff, 32'd1023, 10'd1023);
      end else if (p == 1) begin
        program_domain(32'hfffd_0000, 32'h0003_0000, 32'hffff_ffff, 10'd0);
      end else begin
        divs = $urandom_range(1, 12);
        lo_b = longint'($urandom_range(2000 << 16)) - (1000 << 16);
        span = $urandom_range(1 << 12, 64 << 16);
        inv = (64'(divs) << 32) / 64'(span);
        if ($urandom_range(3) == 0) inv = inv + inv / 4;
        if (inv > 64'hffff_ffff) inv = 64'hffff_ffff;
        if ($urandom_range(7) == 0)
          program_domain(32'(lo_b + span), 32'(lo_b), inv[31:0], divs[INDEX_W-1:0]);
        else
          program_domain(32'(lo_b), 32'(lo_b + span), inv[31:0], divs[INDEX_W-1:0]);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(4) == 0) push_write($urandom_range(TABLE_DEPTH - 1), $urandom);
        else push_lookup(rand_x());
      end
      wait_idle();
    end

    // long receiver hold-off with the sender running flat out
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_off_en = 1'b1;
    for (int n = 0; n < 60; n++) push_lookup(rand_x());
    wait_idle();
    hold_off_en = 1'b0;

    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ilut_pkg.sv
rtl/ilut_ram.sv
rtl/ilut_index.sv
rtl/ilut_blend.sv
rtl/ilut_skid.sv
rtl/interpolating_lookup_table.sv
tb/testbench.sv
